// File: rtl/core/vvfc_pkg.sv
// Shared constants, codes and types for the voxel visible-face cull core.
// No dependencies; imported by every module in rtl/core but vvfc_ram.

package vvfc_pkg;

	localparam int unsigned GRID_SIDE   = 32;
	localparam int unsigned STORE_DEPTH = GRID_SIDE * GRID_SIDE * GRID_SIDE;
	localparam int unsigned HALF_GRID   = STORE_DEPTH / 2;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
	localparam int unsigned COORD_W     = 5;
	localparam int unsigned CMP_W       = COORD_W + 1;
	localparam int unsigned MAT_W       = 8;
	localparam int unsigned FACE_N      = 6;
	localparam int unsigned IDX_W       = 15;
	localparam int unsigned WORD_W      = 62;
	localparam int unsigned STEP_W      = 3;

	// item kinds carried on s_axis_tuser
	localparam logic [1:0] KIND_WRITE   = 2'd0;
	localparam logic [1:0] KIND_QUERY   = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	// read sequence: the cell itself, then one neighbour per step
	localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
	localparam logic [STEP_W-1:0] STEP_TOP    = 3'd1;
	localparam logic [STEP_W-1:0] STEP_BOTTOM = 3'd2;
	localparam logic [STEP_W-1:0] STEP_RIGHT  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_LEFT   = 3'd4;
	localparam logic [STEP_W-1:0] STEP_BACK   = 3'd5;
	localparam logic [STEP_W-1:0] STEP_FRONT  = 3'd6;

	typedef struct packed {
		logic [STEP_W-1:0]  step;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} vvfc_nbr_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              inb;
	} vvfc_nbr_rsp_t;

	function automatic logic [ADDR_W-1:0] cell_addr(
		input logic [COORD_W-1:0] cx,
		input logic [COORD_W-1:0] cy,
		input logic [COORD_W-1:0] cz
	);
		cell_addr = ADDR_W'(cx) + ADDR_W'(cy) * ADDR_W'(GRID_SIDE)
			+ ADDR_W'(cz) * ADDR_W'(GRID_SIDE * GRID_SIDE);
	endfunction

endpackage

// File: rtl/core/vvfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module vvfc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/vvfc_nbr_unit.sv
// Shared neighbour unit: one +/-1 adder and bound compare per step, plus cell address.
// Depends on vvfc_pkg.

module vvfc_nbr_unit
	import vvfc_pkg::*;
(
	input  vvfc_nbr_req_t req,
	output vvfc_nbr_rsp_t rsp
);

	typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;

	axis_t              axis;
	logic [CMP_W-1:0]   delta;
	logic [CMP_W-1:0]   coord;
	logic [CMP_W-1:0]   moved;
	logic [COORD_W-1:0] nx, ny, nz;
	logic               base_in;

	always_comb begin
		case (req.step)
			STEP_TOP: begin
				axis  = AX_Y;
				delta = CMP_W'(1);
			end
			STEP_BOTTOM: begin
				axis  = AX_Y;
				delta = '1;
			end
			STEP_RIGHT: begin
				axis  = AX_X;
				delta = CMP_W'(1);
			end
			STEP_LEFT: begin
				axis  = AX_X;
				delta = '1;
			end
			STEP_BACK: begin
				axis  = AX_Z;
				delta = '1;
			end
			STEP_FRONT: begin
				axis  = AX_Z;
				delta = CMP_W'(1);
			end
			default: begin
				axis  = AX_X;
				delta = '0;
			end
		endcase
	end

	always_comb begin
		case (axis)
			AX_Y:    coord = {1'b0, req.y};
			AX_Z:    coord = {1'b0, req.z};
			default: coord = {1'b0, req.x};
		endcase
	end

	// stepping below zero wraps to all ones, which fails the same bound compare
	assign moved = coord + delta;

	assign nx = (axis == AX_X) ? moved[COORD_W-1:0] : req.x;
	assign ny = (axis == AX_Y) ? moved[COORD_W-1:0] : req.y;
	assign nz = (axis == AX_Z) ? moved[COORD_W-1:0] : req.z;

	assign base_in = ({1'b0, req.x} < CMP_W'(GRID_SIDE))
		&& ({1'b0, req.y} < CMP_W'(GRID_SIDE))
		&& ({1'b0, req.z} < CMP_W'(GRID_SIDE));

	assign rsp.inb  = base_in && (moved < CMP_W'(GRID_SIDE));
	assign rsp.addr = cell_addr(nx, ny, nz);

endmodule

// File: rtl/core/voxel_visible_face_cull_core.sv
// Top level of the voxel visible-face cull core: sequencer, voxel memory, result register.
// Depends on vvfc_pkg, vvfc_ram and vvfc_nbr_unit.
//
//  channel  dir  tdata (low bit up)                       tuser
//  s_axis   in   x[4:0] y[9:5] z[14:10] material[22:15]    kind[1:0]
//  m_axis   out  packed_word[61:0] entry_index[76:62]     overflow[0]
//
// Write and restart items do not hold the block; it stays ready.
// A query holds the block while it makes seven reads (cell and six neighbours)
// through the single read port of the voxel memory, then collects the last read
// in ST_LAST and loads the result, if any, in ST_EMIT.
// After reset the memory is cleared to air, one entry a cycle, with
// s_axis_tready low until all 32768 entries are written.
// A held result stalls only a query that has a result to hand over.

module voxel_visible_face_cull_core
	import vvfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // x, y, z, material, zero pad
	input  logic [1:0]  s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // packed_word, entry_index, zero pad
	output logic [0:0]  m_axis_tuser    // overflow
);

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_LAST, ST_EMIT} state_t;

	state_t               state_q;
	logic [ADDR_W-1:0]    clr_addr_q;
	logic [STEP_W-1:0]    step_q;
	logic                 pend_s1;
	logic [STEP_W-1:0]    step_s1;
	logic                 inb_s1;
	logic [COORD_W-1:0]   x_q, y_q, z_q;
	logic [MAT_W-1:0]     mat_q;
	logic [FACE_N-1:0]    faces_q;
	logic [IDX_W-1:0]     count_q;
	logic                 out_valid_q;
	logic [WORD_W-1:0]    out_word_q;
	logic [IDX_W-1:0]     out_idx_q;
	logic                 out_ovf_q;

	logic [COORD_W-1:0]   in_x, in_y, in_z;
	logic [MAT_W-1:0]     in_mat;
	logic                 in_fire;
	logic                 in_inside;
	logic [ADDR_W-1:0]    in_addr;
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [MAT_W-1:0]     ram_wdata;
	logic                 ram_re;
	logic [MAT_W-1:0]     ram_rdata;
	logic                 rd_air;
	logic                 has_result;
	logic                 list_full;
	logic                 emit_load;
	vvfc_nbr_req_t        nbr_req;
	vvfc_nbr_rsp_t        nbr_rsp;

	assign in_x   = s_axis_tdata[4:0];
	assign in_y   = s_axis_tdata[9:5];
	assign in_z   = s_axis_tdata[14:10];
	assign in_mat = s_axis_tdata[22:15];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign in_inside     = ({1'b0, in_x} < CMP_W'(GRID_SIDE))
		&& ({1'b0, in_y} < CMP_W'(GRID_SIDE))
		&& ({1'b0, in_z} < CMP_W'(GRID_SIDE));
	assign in_addr       = cell_addr(in_x, in_y, in_z);

	assign ram_we    = (state_q == ST_CLEAR)
		|| (in_fire && s_axis_tuser == KIND_WRITE && in_inside);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : in_addr;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : in_mat;
	assign ram_re    = (state_q == ST_READ);

	assign nbr_req.step = step_q;
	assign nbr_req.x    = x_q;
	assign nbr_req.y    = y_q;
	assign nbr_req.z    = z_q;

	vvfc_nbr_unit u_nbr (
		.req (nbr_req),
		.rsp (nbr_rsp)
	);

	vvfc_ram #(
		.WIDTH (MAT_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (nbr_rsp.addr),
		.rdata (ram_rdata)
	);

	// out-of-grid neighbour reads as a hidden face
	assign rd_air     = inb_s1 && (ram_rdata == '0);
	assign has_result = (mat_q != '0) && (faces_q != '0);
	assign list_full  = (count_q >= IDX_W'(HALF_GRID));
	assign emit_load  = (state_q == ST_EMIT) && has_result && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			step_q      <= STEP_CENTER;
			pend_s1     <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_READ);
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						if (s_axis_tuser == KIND_RESTART) begin
							count_q <= '0;
						end
						if (s_axis_tuser == KIND_QUERY && in_inside) begin
							step_q  <= STEP_CENTER;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_FRONT) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!has_result) begin
						state_q <= ST_IDLE;
					end else if (emit_load) begin
						if (!list_full) begin
							count_q <= count_q + IDX_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: coordinates, read pipeline, face collection, result register
	always_ff @(posedge clk) begin
		step_s1 <= step_q;
		inb_s1  <= nbr_rsp.inb;
		if (in_fire) begin
			x_q <= in_x;
			y_q <= in_y;
			z_q <= in_z;
		end
		if (pend_s1) begin
			case (step_s1)
				STEP_CENTER: mat_q      <= inb_s1 ? ram_rdata : '0;
				STEP_TOP:    faces_q[0] <= rd_air;
				STEP_BOTTOM: faces_q[1] <= rd_air;
				STEP_RIGHT:  faces_q[2] <= rd_air;
				STEP_LEFT:   faces_q[3] <= rd_air;
				STEP_BACK:   faces_q[4] <= rd_air;
				STEP_FRONT:  faces_q[5] <= rd_air;
				default:     mat_q      <= mat_q;
			endcase
		end
		if (emit_load) begin
			out_word_q <= {mat_q, 24'd0, faces_q, 3'd0, z_q, 3'd0, y_q, 3'd0, x_q};
			out_idx_q  <= list_full ? IDX_W'(HALF_GRID) : count_q;
			out_ovf_q  <= list_full;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, out_idx_q, out_word_q};
	assign m_axis_tuser  = out_ovf_q;

endmodule

// File: rtl/core/vvfc_checker.sv
// Port-level checks for the voxel visible-face cull core, bound to the top level.
// Depends on vvfc_pkg and voxel_visible_face_cull_core.

module vvfc_checker
	import vvfc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// a query keeps the block busy in the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_QUERY |=> !s_axis_tready)
		else $error("ready during query");

	// every result is a solid cell with at least one open face and clean pad bits above the faces and the index
	a_word_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[61:54] != '0 && m_axis_tdata[29:24] != '0
			&& m_axis_tdata[53:30] == '0 && m_axis_tdata[79:77] == '0)
		else $error("malformed result word");

	// overflow only with the index pinned at half the grid
	a_ovf_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[76:62] == IDX_W'(HALF_GRID))
		else $error("overflow with index below limit");

endmodule

bind voxel_visible_face_cull_core vvfc_checker u_vvfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// File: dv/vvfc_face_checker.sv
`timescale 1ns / 1ps
// Checker for voxel_visible_face_cull_core: keeps its own copy of the voxel grid and list counter,
// predicts culled-face entries from s_axis transfers and compares m_axis transfers to them.
// Depends on vvfc_pkg.

module vvfc_face_checker
	import vvfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // x, y, z, material, zero pad
	input  logic [1:0]  s_axis_tuser,   // kind
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [79:0] m_axis_tdata,   // packed_word, entry_index, zero pad
	input  logic [0:0]  m_axis_tuser,   // overflow
	output int          fail_count,
	output int          pending,
	output int          items_in,
	output int          faces_out,
	output int          overflow_seen
);

	localparam int SIDE = GRID_SIDE;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [IDX_W-1:0]  idx;
		logic              ovf;
	} face_entry_t;

	logic [MAT_W-1:0] grid_mirror [STORE_DEPTH];
	logic [IDX_W-1:0] list_count;
	face_entry_t      expected_faces [$];
	face_entry_t      want;

	// neighbor outside the grid reads as solid, so that face stays hidden
	function automatic logic is_air(input int nx, input int ny, input int nz);
		if (nx < 0 || ny < 0 || nz < 0 || nx >= SIDE || ny >= SIDE || nz >= SIDE)
			return 1'b0;
		return grid_mirror[nx + ny * SIDE + nz * SIDE * SIDE] == '0;
	endfunction

	task automatic cull_cell(input logic [1:0] kind, input logic [23:0] data);
		logic [COORD_W-1:0] cx, cy, cz;
		logic [MAT_W-1:0]   mat;
		logic [FACE_N-1:0]  faces;
		face_entry_t        entry;
		int                 ux, uy, uz, addr;
		cx = data[4:0];
		cy = data[9:5];
		cz = data[14:10];
		mat = data[22:15];
		ux = cx;
		uy = cy;
		uz = cz;
		addr = ux + uy * SIDE + uz * SIDE * SIDE;
		case (kind)
		KIND_WRITE: grid_mirror[addr] = mat;
		KIND_RESTART: list_count = '0;
		KIND_QUERY: begin
			// front back left right bottom top, high bit first
			faces = {is_air(ux, uy, uz + 1), is_air(ux, uy, uz - 1),
				is_air(ux - 1, uy, uz), is_air(ux + 1, uy, uz),
				is_air(ux, uy - 1, uz), is_air(ux, uy + 1, uz)};
			if (grid_mirror[addr] != '0 && faces != '0) begin
				entry.word = {grid_mirror[addr], 24'd0, faces, 3'd0, cz, 3'd0, cy, 3'd0, cx};
				entry.ovf = list_count >= IDX_W'(HALF_GRID);
				if (entry.ovf)
					list_count = IDX_W'(HALF_GRID);
				entry.idx = list_count;
				if (!entry.ovf)
					list_count = list_count + IDX_W'(1);
				expected_faces.push_back(entry);
			end
		end
		default: ;  // spare kind is dropped
		endcase
	endtask

	task automatic check_field(input string field, input logic [WORD_W-1:0] exp_val,
			input logic [WORD_W-1:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, field, exp_val, act_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++)
				grid_mirror[i] = '0;
			list_count = '0;
			expected_faces.delete();
			pending = 0;
		end else begin
			// result first: it can never belong to an item taken at the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				faces_out++;
				if (m_axis_tuser[0])
					overflow_seen++;
				if (expected_faces.size() == 0) begin
					$display("%0t: result with none expected, word 0x%0h index %0d ovf %0b",
						$time, m_axis_tdata[61:0], m_axis_tdata[76:62], m_axis_tuser[0]);
					fail_count++;
				end else begin
					want = expected_faces.pop_front();
					check_field("packed_word", want.word, m_axis_tdata[61:0]);
					check_field("entry_index", WORD_W'(want.idx), WORD_W'(m_axis_tdata[76:62]));
					check_field("overflow", WORD_W'(want.ovf), WORD_W'(m_axis_tuser[0]));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				items_in++;
				cull_cell(s_axis_tuser, s_axis_tdata);
			end
			pending = expected_faces.size();
		end
	end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for voxel_visible_face_cull_core: clock, reset, stimulus, receiver stalls, verdict.
// Depends on vvfc_pkg, the core RTL and vvfc_face_checker.

module tb
	import vvfc_pkg::*;
();

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LONG_HOLD = 400;
	localparam int RANDOM_ITEMS = 1380;
	localparam int BOX_ITEMS = 48;
	localparam int REPEAT_QUERIES = 12;
	localparam int DRAIN_CYCLES = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // x, y, z, material, zero pad
	logic [1:0]  s_axis_tuser = '0;   // kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;        // packed_word, entry_index, zero pad
	logic [0:0]  m_axis_tuser;        // overflow

	int fail_count, pending, items_in, faces_out, overflow_seen;
	int cycle_cnt = 0;
	int burst_left = 0;
	bit steady = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	always #5 clk = ~clk;

	voxel_visible_face_cull_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	vvfc_face_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending),
		.items_in      (items_in),
		.faces_out     (faces_out),
		.overflow_seen (overflow_seen)
	);

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	// one transfer on s_axis, preceded by a random gap at the start of each burst unless steady is set
	task automatic send(input logic [1:0] kind, input logic [4:0] cx, input logic [4:0] cy,
			input logic [4:0] cz, input logic [7:0] mat);
		int gap;
		if (!steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				gap = $urandom_range(0, 6);
				if (gap > 0) begin
					s_axis_tvalid <= 1'b0;
					s_axis_tdata <= 24'($urandom);
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {1'b0, mat, cz, cy, cx};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// corner of a 4x4x4 box, biased toward the grid faces
	function automatic logic [4:0] box_origin();
		case ($urandom_range(0, 3))
		0: return 5'd0;
		1: return 5'd28;
		default: return 5'($urandom_range(0, 28));
		endcase
	endfunction

	function automatic logic [4:0] box_coord(input logic [4:0] origin);
		if ($urandom_range(0, 99) < 85)
			return origin + 5'($urandom_range(0, 3));
		return 5'($urandom_range(0, 31));
	endfunction

	initial begin : sink
		int run_len, stall_len;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				// long back-pressure so the core fills and drops s_axis_tready
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			run_len = $urandom_range(1, 24);
			m_axis_tready <= 1'b1;
			repeat (run_len) @(posedge clk);
			stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (stall_len > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [4:0] ox, oy, oz;
		logic [1:0] kind;
		logic [7:0] mat;
		int pick;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed cases
		send(KIND_QUERY, 5'd0, 5'd0, 5'd0, 8'd0);       // air cell
		send(KIND_WRITE, 5'd0, 5'd0, 5'd0, 8'hFF);
		send(KIND_QUERY, 5'd0, 5'd0, 5'd0, 8'd0);       // low corner, three faces off-grid
		send(KIND_WRITE, 5'd31, 5'd31, 5'd31, 8'h01);
		send(KIND_QUERY, 5'd31, 5'd31, 5'd31, 8'hFF);   // high corner
		send(KIND_WRITE, 5'd10, 5'd10, 5'd10, 8'h80);
		send(KIND_WRITE, 5'd10, 5'd11, 5'd10, 8'h01);
		send(KIND_WRITE, 5'd10, 5'd9, 5'd10, 8'h02);
		send(KIND_WRITE, 5'd11, 5'd10, 5'd10, 8'h04);
		send(KIND_WRITE, 5'd9, 5'd10, 5'd10, 8'h08);
		send(KIND_WRITE, 5'd10, 5'd10, 5'd9, 8'h10);
		send(KIND_WRITE, 5'd10, 5'd10, 5'd11, 8'h20);
		send(KIND_QUERY, 5'd10, 5'd10, 5'd10, 8'd0);    // buried: no entry
		send(KIND_WRITE, 5'd9, 5'd10, 5'd10, 8'h00);
		send(KIND_QUERY, 5'd10, 5'd10, 5'd10, 8'd0);    // left face only
		send(KIND_WRITE, 5'd31, 5'd4, 5'd4, 8'h55);
		send(KIND_QUERY, 5'd31, 5'd4, 5'd4, 8'd0);      // row end must not wrap to next row
		send(KIND_SPARE, 5'd31, 5'd31, 5'd31, 8'hFF);
		send(KIND_RESTART, 5'd0, 5'd0, 5'd0, 8'd0);
		send(KIND_QUERY, 5'd31, 5'd31, 5'd31, 8'd0);    // index back at zero
		send(KIND_WRITE, 5'd0, 5'd0, 5'd0, 8'h00);
		send(KIND_QUERY, 5'd0, 5'd0, 5'd0, 8'd0);

		// random items clustered in small boxes so neighbors interact
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % BOX_ITEMS == 0) begin
				ox = box_origin();
				oy = box_origin();
				oz = box_origin();
			end
			steady = ((i / 200) % 3 == 2);
			if (i == RANDOM_ITEMS / 3)
				hold_req <= 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 45)
				kind = KIND_WRITE;
			else if (pick < 90)
				kind = KIND_QUERY;
			else if (pick < 95)
				kind = KIND_RESTART;
			else
				kind = KIND_SPARE;
			mat = ($urandom_range(0, 9) < 3) ? 8'd0 : 8'($urandom_range(1, 255));
			send(kind, box_coord(ox), box_coord(oy), box_coord(oz), mat);
		end

		// back-to-back queries of one exposed cell, index counting up from a restart
		steady = 1'b1;
		send(KIND_WRITE, 5'd16, 5'd16, 5'd16, 8'h3C);
		send(KIND_WRITE, 5'd16, 5'd17, 5'd16, 8'h00);
		send(KIND_RESTART, 5'd0, 5'd0, 5'd0, 8'd0);
		for (int i = 0; i < REPEAT_QUERIES; i++)
			send(KIND_QUERY, 5'd16, 5'd16, 5'd16, 8'($urandom));
		send(KIND_RESTART, 5'd0, 5'd0, 5'd0, 8'd0);
		send(KIND_QUERY, 5'd16, 5'd16, 5'd16, 8'd0);
		steady = 1'b0;
		s_axis_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d input transfers and %0d face entries, %0d of them flagged overflow,",
			items_in, faces_out, overflow_seen);
		$display("including grid corners, buried cells, row ends, restarts and a long output stall.");
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
